// ===== src/rsch_pkg.sv =====
// Shared types, widths, constants and helpers of the ray/sphere closest-hit unit.
package rsch_pkg;

	localparam int SPHERE_COUNT = 4;
	localparam int FRAC_BITS    = 16;
	localparam int IDX_W        = (SPHERE_COUNT > 1) ? $clog2(SPHERE_COUNT) : 1;

	localparam int POS_W  = 32;
	localparam int DIST_W = 31;
	localparam int OC_W   = POS_W + 1;
	localparam int MUL_W  = OC_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = PROD_W - FRAC_BITS + 3;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int DIVN_W = OC_W + FRAC_BITS;
	localparam int DIVD_W = DIST_W;
	localparam int TENTH_W = 32;

	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam longint FAR_Q = longint'(1000) << FRAC_BITS;
	localparam logic [DIST_W-1:0] MIN_RESET = DIST_W'((ONE_Q + 50) / 100);
	localparam logic [DIST_W-1:0] MAX_RESET =
		(FAR_Q > longint'(2147483647)) ? {DIST_W{1'b1}} : DIST_W'(FAR_Q);
	localparam logic [TENTH_W-1:0] TENTH_Q = TENTH_W'((ONE_Q + 5) / 10);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;

	typedef struct packed {
		logic                     opcode;
		logic [1:0]               sphere_index;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [POS_W-1:0]  dir_x;
		logic signed [POS_W-1:0]  dir_y;
		logic signed [POS_W-1:0]  dir_z;
		logic [DIST_W-1:0]        sphere_radius_in;
	} in_item_t;

	typedef struct packed {
		logic              hit;
		logic [1:0]        hit_index;
		logic [DIST_W-1:0] hit_distance;
		logic              edge_res;
	} out_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
		logic [DIST_W-1:0]       radius;
	} sphere_t;

	typedef struct packed {
		logic              start;
		logic [DIVN_W-1:0] dividend;
		logic [DIVD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVN_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > $signed(ACC_W'(32'h7fffffff))) begin
			r = 32'sh7fffffff;
		end else if (x < -$signed(ACC_W'(33'h080000000))) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(x);
		end
		return r;
	endfunction

endpackage

// ===== src/rsch_sphere_ram.sv =====
// Sphere table memory: one write port, one registered read port.
module rsch_sphere_ram (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [rsch_pkg::IDX_W-1:0] wr_addr,
	input  rsch_pkg::sphere_t         wr_data,
	input  logic                      rd_en,
	input  logic [rsch_pkg::IDX_W-1:0] rd_addr,
	output rsch_pkg::sphere_t         rd_data
);

	rsch_pkg::sphere_t mem [rsch_pkg::SPHERE_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/rsch_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rsch_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rsch_pkg::div_req_t req,
	output rsch_pkg::div_rsp_t rsp
);

	localparam int N_W   = rsch_pkg::DIVN_W;
	localparam int D_W   = rsch_pkg::DIVD_W;
	localparam int CNT_W = $clog2(N_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   num_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign trial = {rem_q, num_q[N_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[N_W-2:0], 1'b0};
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/rsch_sqrt.sv =====
// Integer square root, two radicand bits (one root bit) per cycle.
module rsch_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  rsch_pkg::sqrt_req_t req,
	output rsch_pkg::sqrt_rsp_t rsp
);

	localparam int R_W   = rsch_pkg::RAD_W;
	localparam int Q_W   = rsch_pkg::ROOT_W;
	localparam int CNT_W = $clog2(Q_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [R_W-1:0]   rad_q;
	logic [Q_W-1:0]   root_q;
	logic [Q_W:0]     rem_q;
	logic [Q_W+2:0]   trial_rem;
	logic [Q_W+2:0]   trial;
	logic [Q_W+2:0]   diff;
	logic             ge;

	assign trial_rem = {rem_q, rad_q[R_W-1:R_W-2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign diff      = trial_rem - trial;
	assign ge        = (trial_rem >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[R_W-3:0], 2'b00};
			root_q <= {root_q[Q_W-2:0], ge};
			rem_q  <= ge ? diff[Q_W:0] : trial_rem[Q_W:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

// ===== src/ray_sphere_closest_hit_unit.sv =====
// Top level of the ray/sphere closest-hit unit: sequencer, shared multiplier, table control.
//
// Input channel (in_valid/in_stall/in_data) carries one transaction per item.
// A load transaction writes one sphere entry and marks it valid; it produces no
// result. A trace transaction casts a ray against all valid entries and produces
// exactly one result on out_valid/out_stall/out_data. For each valid sphere a
// trace does a table read, multiply steps, a square root and one division, or
// two when the near root is rejected; an invalid entry is skipped. A near-root
// hit adds three square roots and the outline test. Trace time is set by the
// shared one-bit-per-cycle divider and the shared square-root unit; one item is
// in work at a time. The result register lets the next transaction be accepted
// while a finished result waits; a trace that completes while that result is
// still stalled waits until it is taken. Configuration writes (cfg_wr_en) are
// registered; a new maximum distance applies from the next trace on. Reset
// clears all entry valid bits, restores both distance registers and empties the
// result register.
module ray_sphere_closest_hit_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rsch_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output rsch_pkg::out_item_t             out_data,
	input  logic                            cfg_wr_en,
	input  logic [rsch_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsch_pkg::DIST_W-1:0]     cfg_data
);

	localparam int IDX_W  = rsch_pkg::IDX_W;
	localparam int MUL_W  = rsch_pkg::MUL_W;
	localparam int PROD_W = rsch_pkg::PROD_W;
	localparam int ACC_W  = rsch_pkg::ACC_W;
	localparam int DIST_W = rsch_pkg::DIST_W;
	localparam int DIVN_W = rsch_pkg::DIVN_W;
	localparam int OC_W   = rsch_pkg::OC_W;
	localparam int RAD_W  = rsch_pkg::RAD_W;
	localparam int ROOT_W = rsch_pkg::ROOT_W;
	localparam int F      = rsch_pkg::FRAC_BITS;
	localparam int TD_W   = PROD_W + rsch_pkg::TENTH_W;
	localparam int DEN_W  = PROD_W - F;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MUL  = 10'b0000000010,
		S_ACC  = 10'b0000000100,
		S_SEL  = 10'b0000001000,
		S_RDW  = 10'b0000010000,
		S_SQRT = 10'b0000100000,
		S_DIV  = 10'b0001000000,
		S_NEXT = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	localparam logic [3:0] STEP_A0 = 4'd0;
	localparam logic [3:0] STEP_A1 = 4'd1;
	localparam logic [3:0] STEP_A2 = 4'd2;
	localparam logic [3:0] STEP_B0 = 4'd3;
	localparam logic [3:0] STEP_B1 = 4'd4;
	localparam logic [3:0] STEP_B2 = 4'd5;
	localparam logic [3:0] STEP_C0 = 4'd6;
	localparam logic [3:0] STEP_C1 = 4'd7;
	localparam logic [3:0] STEP_C2 = 4'd8;
	localparam logic [3:0] STEP_C3 = 4'd9;
	localparam logic [3:0] STEP_D0 = 4'd10;
	localparam logic [3:0] STEP_D1 = 4'd11;
	localparam logic [3:0] STEP_E0 = 4'd12;
	localparam logic [3:0] STEP_E1 = 4'd13;

	localparam logic [1:0] SQ_DISC = 2'd0;
	localparam logic [1:0] SQ_SR   = 2'd1;
	localparam logic [1:0] SQ_Q    = 2'd2;
	localparam logic [1:0] SQ_LEN  = 2'd3;

	state_t                      state_q;
	logic [3:0]                  step_q;
	logic [1:0]                  sq_sel_q;
	logic [IDX_W-1:0]            sph_q;
	logic [rsch_pkg::SPHERE_COUNT-1:0] valid_q;
	logic [DIST_W-1:0]           min_q;
	logic [DIST_W-1:0]           max_q;

	logic signed [31:0]          ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
	logic signed [OC_W-1:0]      ocx_q, ocy_q, ocz_q;
	logic [DIST_W-1:0]           r_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [PROD_W-1:0]    bb_q;
	logic [DIST_W-1:0]           a_q;
	logic signed [31:0]          b_q, c_q;
	logic [ROOT_W-1:0]           s_q, q_q, len_q;
	logic                        div_far_q;
	logic                        num_neg_q;
	logic [DEN_W-1:0]            den_q;

	logic [DIST_W-1:0]           best_q;
	logic                        found_q;
	logic [IDX_W-1:0]            win_q;
	logic [ROOT_W-1:0]           win_s_q;
	logic [DIST_W-1:0]           win_r_q;
	logic                        win_far_q;
	logic                        edge_q;

	logic                        out_valid_q;
	rsch_pkg::out_item_t         out_q;

	logic                        in_acc;
	logic                        ram_wr_en;
	logic                        ram_rd_en;
	rsch_pkg::sphere_t           ram_wr;
	rsch_pkg::sphere_t           ram_rd;

	logic signed [MUL_W-1:0]     mul_a, mul_b;
	logic signed [ACC_W-1:0]     prod_sh, acc_sum, acc_dif;
	logic signed [31:0]          sum_sat, dif_sat;
	logic signed [PROD_W:0]      disc;
	logic                        disc_pos;
	logic [TD_W-1:0]             tenth_den, sprod_ext;

	rsch_pkg::sqrt_req_t         sq_req;
	rsch_pkg::sqrt_rsp_t         sq_rsp;
	rsch_pkg::div_req_t          div_req;
	rsch_pkg::div_rsp_t          div_rsp;

	logic [ROOT_W-1:0]           s_cur;
	logic signed [OC_W:0]        numer;
	logic [OC_W:0]               numer_mag;
	logic [DIVN_W:0]             q_ext;
	logic signed [DIVN_W:0]      t_val;
	logic                        t_gt_min, t_lt_best;

	rsch_sphere_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (IDX_W'(in_data.sphere_index)),
		.wr_data (ram_wr),
		.rd_en   (ram_rd_en),
		.rd_addr (sph_q),
		.rd_data (ram_rd)
	);

	rsch_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	rsch_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign ram_wr_en = in_acc && (in_data.opcode == rsch_pkg::OP_LOAD)
		&& (32'(in_data.sphere_index) < rsch_pkg::SPHERE_COUNT);
	assign ram_wr.cx     = in_data.pos_x;
	assign ram_wr.cy     = in_data.pos_y;
	assign ram_wr.cz     = in_data.pos_z;
	assign ram_wr.radius = in_data.sphere_radius_in;
	assign ram_rd_en = (state_q == S_SEL) && valid_q[sph_q];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STEP_A0: begin mul_a = {dx_q[31], dx_q}; mul_b = {dx_q[31], dx_q}; end
			STEP_A1: begin mul_a = {dy_q[31], dy_q}; mul_b = {dy_q[31], dy_q}; end
			STEP_A2: begin mul_a = {dz_q[31], dz_q}; mul_b = {dz_q[31], dz_q}; end
			STEP_B0: begin mul_a = ocx_q; mul_b = {dx_q[31], dx_q}; end
			STEP_B1: begin mul_a = ocy_q; mul_b = {dy_q[31], dy_q}; end
			STEP_B2: begin mul_a = ocz_q; mul_b = {dz_q[31], dz_q}; end
			STEP_C0: begin mul_a = ocx_q; mul_b = ocx_q; end
			STEP_C1: begin mul_a = ocy_q; mul_b = ocy_q; end
			STEP_C2: begin mul_a = ocz_q; mul_b = ocz_q; end
			STEP_C3: begin mul_a = {2'b00, r_q}; mul_b = {2'b00, r_q}; end
			STEP_D0: begin mul_a = {b_q[31], b_q}; mul_b = {b_q[31], b_q}; end
			STEP_D1: begin mul_a = {2'b00, a_q}; mul_b = {c_q[31], c_q}; end
			STEP_E0: begin mul_a = {1'b0, len_q}; mul_b = {2'b00, win_r_q}; end
			STEP_E1: begin mul_a = {1'b0, win_s_q}; mul_b = {1'b0, q_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_sh  = ACC_W'(prod_q >>> F);
	assign acc_sum  = acc_q + prod_sh;
	assign acc_dif  = acc_q - prod_sh;
	assign sum_sat  = rsch_pkg::sat32(acc_sum);
	assign dif_sat  = rsch_pkg::sat32(acc_dif);
	assign disc     = {bb_q[PROD_W-1], bb_q} - {prod_q[PROD_W-1], prod_q};
	assign disc_pos = !disc[PROD_W] && (disc != '0);

	assign tenth_den = TD_W'(den_q) * TD_W'(rsch_pkg::TENTH_Q);
	assign sprod_ext = TD_W'($unsigned(prod_q));

	// Root numerator: -b - s for the near root, -b + s for the far root.
	assign s_cur     = (state_q == S_SQRT) ? sq_rsp.root : s_q;
	assign numer     = (state_q == S_DIV)
		? (-{{2{b_q[31]}}, b_q} + {2'b00, s_cur})
		: (-{{2{b_q[31]}}, b_q} - {2'b00, s_cur});
	assign numer_mag = numer[OC_W] ? (~numer + 1'b1) : numer;

	assign q_ext     = {1'b0, div_rsp.quotient};
	assign t_val     = num_neg_q ? ('0 - q_ext) : q_ext;
	assign t_gt_min  = t_val > $signed({{(DIVN_W + 1 - DIST_W){1'b0}}, min_q});
	assign t_lt_best = t_val < $signed({{(DIVN_W + 1 - DIST_W){1'b0}}, best_q});

	always_comb begin
		sq_req.start     = 1'b0;
		sq_req.radicand  = '0;
		div_req.start    = 1'b0;
		div_req.dividend = {numer_mag[OC_W-1:0], {F{1'b0}}};
		div_req.divisor  = a_q;
		case (state_q)
			S_ACC: begin
				if (step_q == STEP_D1 && disc_pos) begin
					sq_req.start    = 1'b1;
					sq_req.radicand = disc[RAD_W-1:0];
				end
			end
			S_FIN: begin
				if (found_q && !win_far_q) begin
					sq_req.start    = 1'b1;
					sq_req.radicand = RAD_W'(win_r_q) << F;
				end
			end
			S_SQRT: begin
				if (sq_rsp.done) begin
					case (sq_sel_q)
						SQ_DISC: div_req.start = 1'b1;
						SQ_SR: begin
							sq_req.start    = 1'b1;
							sq_req.radicand = RAD_W'(sq_rsp.root) << F;
						end
						SQ_Q: begin
							sq_req.start    = 1'b1;
							sq_req.radicand = RAD_W'(a_q) << F;
						end
						default: sq_req.start = 1'b0;
					endcase
				end
			end
			S_DIV: begin
				if (div_rsp.done && !div_far_q && !t_gt_min) begin
					div_req.start = 1'b1;
				end
			end
			default: sq_req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= rsch_pkg::MIN_RESET;
			max_q <= rsch_pkg::MAX_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rsch_pkg::CFG_MIN_DISTANCE: min_q <= cfg_data;
				rsch_pkg::CFG_MAX_DISTANCE: max_q <= cfg_data;
				default: min_q <= min_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_A0;
			sq_sel_q    <= SQ_DISC;
			sph_q       <= '0;
			valid_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loaded in S_DONE replaces the one taken at this edge.
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (ram_wr_en) begin
				valid_q[IDX_W'(in_data.sphere_index)] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_data.opcode == rsch_pkg::OP_TRACE) begin
						step_q  <= STEP_A0;
						found_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					case (step_q)
						STEP_A2: begin
							if (sum_sat[31] || sum_sat == '0) begin
								state_q <= S_DONE;
							end else begin
								sph_q   <= '0;
								state_q <= S_SEL;
							end
						end
						STEP_D1: state_q <= disc_pos ? S_SQRT : S_NEXT;
						STEP_E1: state_q <= S_DONE;
						default: begin
							step_q  <= step_q + 4'd1;
							state_q <= S_MUL;
						end
					endcase
					if (step_q == STEP_D1) begin
						sq_sel_q <= SQ_DISC;
					end
				end
				S_SEL: state_q <= valid_q[sph_q] ? S_RDW : S_NEXT;
				S_RDW: begin
					step_q  <= STEP_B0;
					state_q <= S_MUL;
				end
				S_SQRT: begin
					if (sq_rsp.done) begin
						case (sq_sel_q)
							SQ_DISC: state_q <= S_DIV;
							SQ_SR:   sq_sel_q <= SQ_Q;
							SQ_Q:    sq_sel_q <= SQ_LEN;
							SQ_LEN: begin
								step_q  <= STEP_E0;
								state_q <= S_MUL;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (t_gt_min && t_lt_best) begin
							found_q <= 1'b1;
						end
						if (t_gt_min || div_far_q) begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (sph_q == IDX_W'(rsch_pkg::SPHERE_COUNT - 1)) begin
						state_q <= S_FIN;
					end else begin
						sph_q   <= sph_q + IDX_W'(1);
						state_q <= S_SEL;
					end
				end
				S_FIN: begin
					if (found_q && !win_far_q) begin
						sq_sel_q <= SQ_SR;
						state_q  <= S_SQRT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				ox_q    <= in_data.pos_x;
				oy_q    <= in_data.pos_y;
				oz_q    <= in_data.pos_z;
				dx_q    <= in_data.dir_x;
				dy_q    <= in_data.dir_y;
				dz_q    <= in_data.dir_z;
				acc_q   <= '0;
				best_q  <= max_q;
				win_q   <= '0;
				edge_q  <= 1'b0;
			end
			S_ACC: begin
				case (step_q)
					STEP_A2: a_q <= sum_sat[DIST_W-1:0];
					STEP_B2: begin
						b_q   <= sum_sat;
						acc_q <= '0;
					end
					STEP_C3: c_q <= dif_sat;
					STEP_D0: bb_q <= prod_q;
					STEP_D1: acc_q <= '0;
					STEP_E0: den_q <= DEN_W'(prod_q >>> F);
					STEP_E1: edge_q <= (sprod_ext < tenth_den);
					default: acc_q <= acc_sum;
				endcase
			end
			S_RDW: begin
				ocx_q <= {ox_q[31], ox_q} - {ram_rd.cx[31], ram_rd.cx};
				ocy_q <= {oy_q[31], oy_q} - {ram_rd.cy[31], ram_rd.cy};
				ocz_q <= {oz_q[31], oz_q} - {ram_rd.cz[31], ram_rd.cz};
				r_q   <= ram_rd.radius;
				acc_q <= '0;
			end
			S_SQRT: begin
				if (sq_rsp.done) begin
					case (sq_sel_q)
						SQ_DISC: begin
							s_q       <= sq_rsp.root;
							div_far_q <= 1'b0;
							num_neg_q <= numer[OC_W];
						end
						SQ_Q:    q_q   <= sq_rsp.root;
						SQ_LEN:  len_q <= sq_rsp.root;
						default: s_q   <= s_q;
					endcase
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (t_gt_min && t_lt_best) begin
						best_q    <= t_val[DIST_W-1:0];
						win_q     <= sph_q;
						win_s_q   <= s_q;
						win_r_q   <= r_q;
						win_far_q <= div_far_q;
					end
					if (div_req.start) begin
						div_far_q <= 1'b1;
						num_neg_q <= numer[OC_W];
					end
				end
			end
			S_FIN: begin
				if (!(found_q && !win_far_q)) begin
					edge_q <= found_q;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_q.hit          <= found_q;
					out_q.hit_index    <= found_q ? 2'(win_q) : 2'd0;
					out_q.hit_distance <= best_q;
					out_q.edge_res     <= edge_q;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != '0))
		else $error("divider started with a zero divisor");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDW) |-> ($past(state_q) == S_SEL && valid_q[sph_q]))
		else $error("sphere read of an entry that is not loaded");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data.hit_index == '0 && !out_data.edge_res))
		else $error("miss result carries hit fields");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |->
		(out_data.hit_distance < max_q && out_data.hit_distance > min_q))
		else $error("hit distance outside the distance window");

endmodule
